// ===== hdl/set_assoc_cache_directory_core_assert.svh =====
// Assertion macros shared by the checker of the cache directory.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef SET_ASSOC_CACHE_DIRECTORY_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_DIRECTORY_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SACD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache directory check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SACD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache directory check failed");

`endif

// ===== hdl/sacd_pkg.sv =====
// Shared types and geometry constants of the set-associative cache directory.
// Used by every module of the block but sacd_ram; it depends on nothing else.
`timescale 1ns / 1ps

package sacd_pkg;

  localparam int SET_COUNT    = 128;
  localparam int WAY_COUNT    = 8;
  localparam int LINE_BYTES   = 64;
  localparam int ADDRESS_BITS = 27;

  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS    = $clog2(SET_COUNT);
  localparam int WAY_BITS    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int LINE_BITS   = ADDRESS_BITS - OFFSET_BITS;
  localparam int TAG_BITS    = LINE_BITS - SET_BITS;
  // Offset plus length never reaches twice the line size.
  localparam int SUM_BITS    = OFFSET_BITS + 1;

  // Fixed field widths of the result item.
  localparam int WAY_FIELD_BITS  = 3;
  localparam int LINE_FIELD_BITS = 21;

  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [WAY_BITS-1:0]  way_idx_t;
  typedef logic [SET_BITS-1:0]  set_idx_t;
  typedef logic [LINE_BITS-1:0] line_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // One memory row holds the whole set.
  typedef struct packed {
    logic [WAY_COUNT-1:0] valid;
    tag_t [WAY_COUNT-1:0] tags;
  } set_row_t;

  typedef struct packed {
    logic                    hit;
    way_idx_t                chosen;
    logic                    fill;
    logic                    advance;
  } sel_t;

  typedef struct packed {
    logic                    command;
    logic [ADDRESS_BITS-1:0] byte_address;
    logic [2:0]              access_length;
  } in_item_t;

  typedef struct packed {
    logic                       hit;
    logic [WAY_FIELD_BITS-1:0]  way;
    logic                       fill_needed;
    logic                       forward_write;
    logic [LINE_FIELD_BITS-1:0] line_number;
    logic                       last;
  } out_item_t;

endpackage

// ===== hdl/sacd_ram.sv =====
// Generic single-clock memory with one write port and one registered read port.
// Standalone; holds the set rows of the cache directory.
`timescale 1ns / 1ps

module sacd_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sacd_way_sel.sv =====
// Tag compare and way choice for one set row of the cache directory.
// Depends on sacd_pkg for the row layout and the selection struct.
`timescale 1ns / 1ps

module sacd_way_sel (
  input  sacd_pkg::set_row_t row,
  input  sacd_pkg::tag_t     tag,
  input  logic               is_write,
  input  sacd_pkg::way_idx_t victim,
  output sacd_pkg::sel_t     sel
);

  logic               hit;
  logic               free;
  sacd_pkg::way_idx_t hit_way;
  sacd_pkg::way_idx_t free_way;

  // Lowest-numbered matching way and lowest-numbered invalid way.
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < sacd_pkg::WAY_COUNT; w++) begin
      if (row.valid[w]) begin
        if (!hit && row.tags[w] == tag) begin
          hit     = 1'b1;
          hit_way = sacd_pkg::WAY_BITS'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_way = sacd_pkg::WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    sel.hit     = hit;
    sel.fill    = !hit && !is_write;
    sel.advance = !hit && !is_write && !free;
    priority if (hit) begin
      sel.chosen = hit_way;
    end else if (is_write) begin
      sel.chosen = '0;
    end else if (free) begin
      sel.chosen = free_way;
    end else begin
      sel.chosen = victim;
    end
  end

endmodule

// ===== hdl/set_assoc_cache_directory_core.sv =====
// Tag directory of a set-associative, write-through, no-write-allocate cache.
// Depends on sacd_pkg, sacd_ram and sacd_way_sel.
//
// After reset the block sweeps the set memory once to clear all valid bits,
// one set per cycle; no item is taken meanwhile. Each set lookup is a read
// of the set row from the memory followed by compare, way choice and
// write-back; for an access that crosses into the next line, the read of
// the second set overlaps the first write-back. Items are taken one at a
// time; a stalled result register holds the lookup until it drains. A read
// miss allocates the first invalid way, or else the way named by a
// round-robin victim pointer.
`timescale 1ns / 1ps

module set_assoc_cache_directory_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sacd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sacd_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t                        state_r;
  sacd_pkg::set_idx_t            clr_cnt_r;
  logic                          is_write_r;
  sacd_pkg::line_t               line_r;
  logic                          second_r;
  sacd_pkg::way_idx_t            victim_r;
  logic                          out_valid_r;
  sacd_pkg::out_item_t           out_data_r;

  logic                          accept;
  logic                          look_go;
  sacd_pkg::line_t               in_line;
  sacd_pkg::line_t               next_line;
  logic [sacd_pkg::SUM_BITS-1:0] end_sum;
  logic                          crosses;
  logic                          rd_en;
  sacd_pkg::set_idx_t            rd_addr;
  logic                          wr_en;
  sacd_pkg::set_idx_t            wr_addr;
  sacd_pkg::set_row_t            wr_row;
  logic [$bits(sacd_pkg::set_row_t)-1:0] rd_bits;
  sacd_pkg::set_row_t            row;
  sacd_pkg::tag_t                cur_tag;
  sacd_pkg::sel_t                sel;
  sacd_pkg::out_item_t           result;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign look_go   = (state_r == S_LOOK) && (!out_valid_r || !out_stall);

  assign in_line   = in_data.byte_address[sacd_pkg::ADDRESS_BITS-1:sacd_pkg::OFFSET_BITS];
  assign next_line = line_r + sacd_pkg::LINE_BITS'(1);
  assign end_sum   = sacd_pkg::SUM_BITS'(in_data.byte_address[sacd_pkg::OFFSET_BITS-1:0])
                   + sacd_pkg::SUM_BITS'(in_data.access_length);
  assign crosses   = end_sum > sacd_pkg::SUM_BITS'(sacd_pkg::LINE_BYTES);

  // The second set of a crossing access is read while the first is written back.
  assign rd_en   = accept || (look_go && second_r);
  assign rd_addr = accept ? in_line[sacd_pkg::SET_BITS-1:0]
                          : next_line[sacd_pkg::SET_BITS-1:0];

  assign row     = sacd_pkg::set_row_t'(rd_bits);
  assign cur_tag = line_r[sacd_pkg::LINE_BITS-1:sacd_pkg::SET_BITS];

  sacd_way_sel u_way_sel (
    .row      (row),
    .tag      (cur_tag),
    .is_write (is_write_r),
    .victim   (victim_r),
    .sel      (sel)
  );

  always_comb begin
    wr_row = row;
    wr_row.valid[sel.chosen] = 1'b1;
    wr_row.tags[sel.chosen]  = cur_tag;
    wr_en   = 1'b0;
    wr_addr = line_r[sacd_pkg::SET_BITS-1:0];
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_row  = '0;
    end else if (look_go && sel.fill) begin
      wr_en = 1'b1;
    end
  end

  sacd_ram #(
    .DEPTH (sacd_pkg::SET_COUNT),
    .WIDTH ($bits(sacd_pkg::set_row_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  always_comb begin
    result.hit           = sel.hit;
    result.way           = sacd_pkg::WAY_FIELD_BITS'(sel.chosen);
    result.fill_needed   = sel.fill;
    result.forward_write = is_write_r;
    result.line_number   = sacd_pkg::LINE_FIELD_BITS'(line_r);
    result.last          = !second_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      victim_r    <= '0;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      if (look_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + sacd_pkg::SET_BITS'(1);
          if (clr_cnt_r == sacd_pkg::SET_BITS'(sacd_pkg::SET_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_write_r <= in_data.command == sacd_pkg::CMD_WRITE;
            line_r     <= in_line;
            second_r   <= crosses;
            state_r    <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (look_go) begin
            out_data_r  <= result;
            if (sel.advance) begin
              if (victim_r == sacd_pkg::WAY_BITS'(sacd_pkg::WAY_COUNT - 1)) begin
                victim_r <= '0;
              end else begin
                victim_r <= victim_r + sacd_pkg::WAY_BITS'(1);
              end
            end
            if (second_r) begin
              line_r   <= next_line;
              second_r <= 1'b0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== hdl/sacd_checker.sv =====
// Port-level checks of the cache directory, bound to the top level.
// Depends on sacd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "set_assoc_cache_directory_core_assert.svh"

module sacd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sacd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input sacd_pkg::out_item_t out_data
);

  logic read_miss;

  assign read_miss = !out_data.hit && !out_data.forward_write;

  // Items are worked on one at a time, so an accepted item closes the input.
  `SACD_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)

  // A fill is asked only for a read that missed.
  `SACD_ASSERT_NOW(a_fill_on_read_miss, clk, rst_n, out_valid && out_data.fill_needed, read_miss)

  `SACD_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && out_stall, out_valid)

  `SACD_ASSERT_NEXT(a_out_data_holds, clk, rst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind set_assoc_cache_directory_core sacd_checker u_sacd_checker (.*);

// ===== verif/set_assoc_cache_directory_core_tb.sv =====
// Self-checking testbench of the set-associative cache directory core.
// Depends on sacd_pkg and set_assoc_cache_directory_core; a scoreboard class
// predicts every lookup and checks the results in order.
`timescale 1ns / 1ps

module tb;
  import sacd_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;

  // Predicts hit, way and fill of each set lookup from its own copy of the
  // directory, and holds the lookups still to come out of the block.
  class lookup_scoreboard;
    bit       valid_bits [SET_COUNT][WAY_COUNT];
    tag_t     tags       [SET_COUNT][WAY_COUNT];
    way_idx_t victim;
    out_item_t expected_lookups [$];
    int errors;

    function new();
      for (int s = 0; s < SET_COUNT; s++)
        for (int w = 0; w < WAY_COUNT; w++) valid_bits[s][w] = 1'b0;
      victim = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    function out_item_t lookup_line(bit is_write, line_t line, bit last_one);
      set_idx_t  s;
      tag_t      t;
      int        found;
      int        free_way;
      way_idx_t  chosen;
      bit        fill;
      out_item_t r;
      s = line[SET_BITS-1:0];
      t = line[LINE_BITS-1:SET_BITS];
      found = -1;
      free_way = -1;
      chosen = '0;
      fill = 1'b0;
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (valid_bits[s][w]) begin
          if (found < 0 && tags[s][w] == t) found = w;
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      if (found >= 0) begin
        chosen = way_idx_t'(found);
      end else if (!is_write) begin
        // The round-robin pointer moves only when the set is full.
        if (free_way >= 0) begin
          chosen = way_idx_t'(free_way);
        end else begin
          chosen = victim;
          victim = way_idx_t'((int'(victim) + 1) % WAY_COUNT);
        end
        valid_bits[s][chosen] = 1'b1;
        tags[s][chosen] = t;
        fill = 1'b1;
      end
      r.hit           = (found >= 0);
      r.way           = chosen;
      r.fill_needed   = fill;
      r.forward_write = is_write;
      r.line_number   = line;
      r.last          = last_one;
      return r;
    endfunction

    function void note_access(in_item_t it);
      bit    is_write;
      int    offset;
      line_t line;
      bit    crosses;
      is_write = (it.command == CMD_WRITE);
      offset   = int'(it.byte_address[OFFSET_BITS-1:0]);
      line     = it.byte_address[ADDRESS_BITS-1:OFFSET_BITS];
      crosses  = (offset + int'(it.access_length)) > LINE_BYTES;
      expected_lookups.push_back(lookup_line(is_write, line, !crosses));
      // The next line wraps to zero at the top of the address space.
      if (crosses) expected_lookups.push_back(lookup_line(is_write, line + line_t'(1), 1'b1));
    endfunction

    function string show(out_item_t r);
      return $sformatf("hit=%0d way=%0d fill=%0d fwd=%0d line=%06h last=%0d",
                       r.hit, r.way, r.fill_needed, r.forward_write, r.line_number, r.last);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      if (expected_lookups.size() == 0) begin
        note_error($sformatf("lookup result with none pending: %s", show(got)));
        return;
      end
      want = expected_lookups.pop_front();
      bad = (got.hit !== want.hit) || (got.way !== want.way) ||
            (got.fill_needed !== want.fill_needed) ||
            (got.forward_write !== want.forward_write) ||
            (got.line_number !== want.line_number) || (got.last !== want.last);
      if (bad) note_error($sformatf("lookup mismatch: expected %s, got %s",
                                    show(want), show(got)));
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  lookup_scoreboard sb = new();

  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  int phase_num       = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;
  int cycles          = 0;

  tag_t     tag_pool [10];
  set_idx_t set_pool [3];

  set_assoc_cache_directory_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** set_assoc_cache_directory_core: FAILED **");
      $finish;
    end
  end

  // Result side: check each lookup result taken, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall == 1'b0) sb.check_result(out_data);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (phase_num == 3 && !hold_done) begin
        // One long hold-off so the block backs up and stalls its input.
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [ADDRESS_BITS-1:0] addr_of(tag_t t, set_idx_t s, int off);
    return {t, s, OFFSET_BITS'(off)};
  endfunction

  function automatic in_item_t make_access(cmd_t c, logic [ADDRESS_BITS-1:0] a, int len);
    in_item_t it;
    it.command       = c;
    it.byte_address  = a;
    it.access_length = 3'(len);
    return it;
  endfunction

  function automatic in_item_t random_access();
    in_item_t it;
    int       off;
    if ($urandom_range(99) < 80) begin
      // Few sets and tags, so that hits, evictions and crossings are common.
      off = $urandom_range(1) ? $urandom_range(63, 58) : $urandom_range(63);
      it.byte_address = addr_of(tag_pool[$urandom_range(9)], set_pool[$urandom_range(2)], off);
    end else begin
      it.byte_address = ADDRESS_BITS'($urandom);
    end
    it.command = ($urandom_range(99) < 60) ? CMD_READ : CMD_WRITE;
    it.access_length = ($urandom_range(99) < 85) ? 3'($urandom_range(4, 1))
                                                 : 3'($urandom_range(7));
    return it;
  endfunction

  task automatic send_access(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_access(item);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_phase(input int n, input int s_pct, input int r_pct);
    sender_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    phase_num     <= n;
  endtask

  task automatic run_directed();
    // Fill set 5: miss, hit, write hit, write miss, then every way.
    send_access(make_access(CMD_READ,  addr_of(14'd1, 7'd5, 0), 1));
    send_access(make_access(CMD_READ,  addr_of(14'd1, 7'd5, 8), 2));
    send_access(make_access(CMD_WRITE, addr_of(14'd1, 7'd5, 4), 4));
    send_access(make_access(CMD_WRITE, addr_of(14'd2, 7'd5, 0), 3));
    for (int t = 2; t <= 8; t++)
      send_access(make_access(CMD_READ, addr_of(14'(t), 7'd5, 16), 4));
    // Set is full now: the victim pointer picks the way.
    send_access(make_access(CMD_READ,  addr_of(14'd9, 7'd5, 0), 1));
    send_access(make_access(CMD_READ,  addr_of(14'd1, 7'd5, 0), 1));
    // Accesses that run into the next line, and ones that just fit.
    send_access(make_access(CMD_READ,  addr_of(14'd3, 7'd5, 62), 4));
    send_access(make_access(CMD_WRITE, addr_of(14'd3, 7'd5, 63), 2));
    send_access(make_access(CMD_READ,  addr_of(14'd3, 7'd5, 63), 0));
    send_access(make_access(CMD_READ,  addr_of(14'd4, 7'd5, 57), 7));
    send_access(make_access(CMD_READ,  addr_of(14'd4, 7'd5, 58), 7));
    send_access(make_access(CMD_WRITE, addr_of(14'd4, 7'd5, 59), 5));
    send_access(make_access(CMD_READ,  addr_of(14'd4, 7'd5, 59), 6));
    // Set 127 rolls over into set 0 of the next tag.
    send_access(make_access(CMD_READ,  addr_of(14'd5, 7'd127, 63), 2));
    // The top of the address space wraps to line zero.
    send_access(make_access(CMD_READ,  '1, 4));
    send_access(make_access(CMD_WRITE, '0, 1));
    send_access(make_access(CMD_WRITE, '1, 1));
  endtask

  initial begin
    for (int i = 0; i < 10; i++) tag_pool[i] = tag_t'($urandom);
    set_pool[0] = set_idx_t'($urandom);
    set_pool[1] = set_idx_t'($urandom);
    set_pool[2] = 7'd127;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_phase(1, 11, 71);
    run_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        wait_drained();
        set_phase(2, 71, 11);
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        set_phase(3, 0, 0);
      end
      send_access(random_access());
    end
    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** set_assoc_cache_directory_core: PASSED **");
    end else begin
      $display("** set_assoc_cache_directory_core: FAILED **");
    end
    $finish;
  end

endmodule
